[hdl/binary_to_decimal_ascii_defines.svh]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter assertion macros
// Shared concurrent assertion forms for the converter's checker. Each macro
// expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter package
// Types and constants shared by the converter and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    // Width of the input word port; only the low VALUE_WIDTH bits are used.
    localparam int VALUE_PORT_W = 64;

    // Default converted width.
    localparam int VALUE_WIDTH_DEFAULT = 64;

    // Width of one BCD digit and of one output character code.
    localparam int BCD_DIGIT_W = 4;
    localparam int CHAR_W      = 6;

    // ASCII codes of the lowest and highest decimal digit, cut to CHAR_W bits.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    // Double-dabble correction threshold and offset.
    localparam logic [BCD_DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [BCD_DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_CONVERT = 4'b0010,
        ST_SKIP    = 4'b0100,
        ST_EMIT    = 4'b1000
    } b2da_state_t;

endpackage

`default_nettype wire

[hdl/binary_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter
// Converts one unsigned binary word into its decimal digits as ASCII codes,
// most significant digit first, with leading zeros suppressed.
// ----------------------------------------------------------------------------
// Each accepted word is turned into a run of 1 to NUM_DIGITS output words
// (20 for the default 64-bit width). A zero input gives the single character
// '0'. The last word of every run carries last_digit high. Only the low
// VALUE_WIDTH bits of value are converted; higher bits are ignored. The block
// handles one input word at a time and holds src_stall high until the last
// digit of the current run has been taken. Each word goes through one
// shift-add-3 step per input bit in the shared BCD adjust unit; then the
// suppressed leading zeros are dropped one at a time, and then one digit is
// emitted per accepted output word.
`default_nettype none

module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Input channel.
    input  wire logic                    src_valid,
    output logic                         src_stall,
    input  wire logic [VALUE_PORT_W-1:0] value,
    // Output channel.
    output logic                         dst_valid,
    input  wire logic                    dst_stall,
    output logic [CHAR_W-1:0]            digit_char,
    output logic                         last_digit
);

    // Decimal digits needed for the largest VALUE_WIDTH-bit number:
    // floor(W * log10(2)) + 1, with log10(2) approximated by 1233 / 4096.
    localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W      = NUM_DIGITS * BCD_DIGIT_W;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    b2da_state_t              state_reg, state_next;
    logic [VALUE_WIDTH-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]         bcd_reg, bcd_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic [BCD_W-1:0]         bcd_adj;
    logic [BCD_DIGIT_W-1:0]   top_digit;
    logic                     cnt_one;
    logic                     src_take;
    logic                     dst_take;

    // The shared adjust unit: every BCD digit of five or more gets three
    // added, so the following left shift carries correctly into the next
    // decimal place.
    always_comb
    begin
        logic [BCD_DIGIT_W-1:0] nib;
        nib     = '0;
        bcd_adj = bcd_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            nib = bcd_reg[i*BCD_DIGIT_W +: BCD_DIGIT_W];
            if (nib >= DABBLE_LIMIT)
            begin
                bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = nib + DABBLE_ADD;
            end
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: BCD_DIGIT_W];
    assign cnt_one   = (cnt_reg == CNT_W'(1));
    assign src_take  = src_valid && !src_stall;
    assign dst_take  = dst_valid && !dst_stall;

    // Sequencer. CONVERT runs one shift-add-3 step per input bit, SKIP
    // drops leading zero digits while more than one digit remains, and EMIT
    // hands out one digit per accepted output word.
    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (src_take)
                begin
                    bin_next   = value[VALUE_WIDTH-1:0];
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_WIDTH);
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                if (cnt_one)
                begin
                    cnt_next   = CNT_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == '0) && !cnt_one)
                begin
                    bcd_next = {bcd_reg[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (dst_take)
                begin
                    if (cnt_one)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bcd_next = {bcd_reg[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers carry payload only and need no reset.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // The input is held off in every state but IDLE; the output word comes
    // straight from registers, so it stays put while the receiver stalls.
    assign src_stall  = (state_reg != ST_IDLE);
    assign dst_valid  = (state_reg == ST_EMIT);
    assign digit_char = ASCII_ZERO + CHAR_W'(top_digit);
    assign last_digit = cnt_one;

endmodule

`default_nettype wire

[hdl/b2da_checker.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter checker
// Port-level assertions on the converter, attached to it by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_decimal_ascii_defines.svh"

module b2da_checker
    import b2da_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    src_valid,
    input wire logic                    src_stall,
    input wire logic                    dst_valid,
    input wire logic                    dst_stall,
    input wire logic [CHAR_W-1:0]       digit_char,
    input wire logic                    last_digit
);

    logic src_take;
    logic dst_take;

    assign src_take = src_valid && !src_stall;
    assign dst_take = dst_valid && !dst_stall;

    `B2DA_ASSERT_NOW(a_char_range, dst_valid, (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_NINE), "digit_char is not a decimal digit")

    `B2DA_ASSERT_NOW(a_busy_while_emit, dst_valid, src_stall, "input taken while digits are still pending")

    `B2DA_ASSERT_NEXT(a_busy_after_take, src_take, src_stall && !dst_valid, "converter not busy after taking a word")

    `B2DA_ASSERT_NEXT(a_run_ends, dst_take && last_digit, !dst_valid, "digits continue after the last digit")

    `B2DA_ASSERT_NEXT(a_hold_stalled, dst_valid && dst_stall, dst_valid && $stable(digit_char) && $stable(last_digit), "stalled output word changed")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

`default_nettype wire

[sim/binary_to_decimal_ascii_tb.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter testbench
// Drives binary words into the converter and checks every emitted digit
// character and its last-digit flag against typed text or a predictor. A
// short table of directed words is followed by random words, with bursty
// input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_tb;
    import b2da_pkg::*;

    localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
    localparam logic [VALUE_PORT_W-1:0] VALUE_MASK =
        {VALUE_PORT_W{1'b1}} >> (VALUE_PORT_W - VALUE_WIDTH);
    localparam logic [VALUE_PORT_W-1:0] DECIMAL_BASE = 10;

    localparam int RANDOM_WORDS    = 220;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = VALUE_WIDTH + 24;
    localparam int CYCLE_LIMIT     = 600000;

    // One expected output word: the character code and its end-of-run flag.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } digit_expect_t;

    // One directed row. An empty text means the predictor supplies the digits.
    typedef struct {
        logic [VALUE_PORT_W-1:0] word;
        string                   text;
    } stimulus_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    src_valid = 1'b0;
    logic                    src_stall;
    logic [VALUE_PORT_W-1:0] value = '0;
    logic                    dst_valid;
    logic                    dst_stall = 1'b0;
    logic [CHAR_W-1:0]       digit_char;
    logic                    last_digit;

    digit_expect_t pending_digits[$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            burst_left = 0;
    bit            random_started = 1'b0;

    binary_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .value     (value),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .digit_char(digit_char),
        .last_digit(last_digit)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Decimal digits of the masked word, most significant first, leading
    // zeros suppressed; zero still yields one digit.
    function automatic void predict_decimal_digits(input logic [VALUE_PORT_W-1:0] word);
        logic [VALUE_PORT_W-1:0] rest;
        logic [3:0]              msd_first[$];
        digit_expect_t           entry;
        rest = word & VALUE_MASK;
        do
        begin
            msd_first.push_front(4'(rest % DECIMAL_BASE));
            rest = rest / DECIMAL_BASE;
        end
        while (rest != 0);
        foreach (msd_first[i])
        begin
            entry.code = ASCII_ZERO + {2'b00, msd_first[i]};
            entry.last = (i == msd_first.size() - 1);
            pending_digits.push_back(entry);
        end
    endfunction

    // Offers one word and waits for it to be taken. The expected digits are
    // queued at acceptance, either from typed text or from the predictor.
    // Between bursts the valid line drops for a random gap.
    task automatic offer_word(input logic [VALUE_PORT_W-1:0] word, input string text);
        digit_expect_t entry;
        src_valid <= 1'b1;
        value     <= word;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        if (text.len() == 0)
            predict_decimal_digits(word);
        else
        begin
            for (int i = 0; i < text.len(); i++)
            begin
                entry.code = CHAR_W'(text[i]);
                entry.last = (i == text.len() - 1);
                pending_digits.push_back(entry);
            end
        end
        @(negedge clk);
        if (burst_left == 0)
        begin
            src_valid <= 1'b0;
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 4)) @(negedge clk);
            else
                repeat ($urandom_range(1, 120)) @(negedge clk);
            burst_left = $urandom_range(0, 20);
        end
        else
            burst_left--;
    endtask

    // Output side: stretches of no stall, light, medium and heavy stalling,
    // and once, early in the random part, a long hold-off so that the block
    // stays busy and pushes back on the input while words keep coming.
    initial
    begin : stall_pattern
        int  mode;
        int  stretch;
        bit  hold_off_done;
        hold_off_done = 1'b0;
        forever
        begin
            if (random_started && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                @(negedge clk);
                dst_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(1, 60);
            repeat (stretch)
            begin
                @(negedge clk);
                case (mode)
                    0:       dst_stall <= 1'b0;
                    1:       dst_stall <= ($urandom_range(0, 3) == 0);
                    2:       dst_stall <= ($urandom_range(0, 1) == 0);
                    default: dst_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Every taken output word is matched against the oldest expectation.
    always @(posedge clk)
    begin : digit_check
        digit_expect_t expected;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected word: digit_char %0d last_digit %0b",
                       digit_char, last_digit);
                error_count++;
            end
            else
            begin
                expected = pending_digits.pop_front();
                if (digit_char !== expected.code)
                begin
                    $error("digit_char: expected %0d, got %0d", expected.code, digit_char);
                    error_count++;
                end
                if (last_digit !== expected.last)
                begin
                    $error("last_digit: expected %0b, got %0b", expected.last, last_digit);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d digits outstanding",
                   cycle_count, pending_digits.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        stimulus_row_t           rows[$];
        logic [VALUE_PORT_W-1:0] word;
        logic [VALUE_PORT_W-1:0] power;
        int                      pick;
        int                      nbits;

        // Extremes and digit-count boundaries; the all-ones and all-zero words
        // between them drive every input bit both ways.
        rows.push_back('{64'd0, "0"});
        rows.push_back('{64'd1, "1"});
        rows.push_back('{64'd9, "9"});
        rows.push_back('{64'd10, "10"});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"});
        rows.push_back('{64'h8000_0000_0000_0000, "9223372036854775808"});
        rows.push_back('{64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"});
        rows.push_back('{64'd10000000000000000000, "10000000000000000000"});
        rows.push_back('{64'd9999999999999999999, "9999999999999999999"});
        rows.push_back('{64'd0, "0"});
        rows.push_back('{64'd5, ""});
        rows.push_back('{64'd90, ""});
        rows.push_back('{64'd99, ""});
        rows.push_back('{64'd100, ""});
        rows.push_back('{64'd1000000, ""});
        rows.push_back('{64'h0000_0000_FFFF_FFFF, ""});
        rows.push_back('{64'h0000_0001_0000_0000, ""});
        rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, ""});
        rows.push_back('{64'h5555_5555_5555_5555, ""});
        rows.push_back('{64'h0123_4567_89AB_CDEF, ""});
        rows.push_back('{64'd1234567890123456789, ""});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFE, ""});

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            offer_word(rows[i].word, rows[i].text);

        random_started = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            word = {$urandom, $urandom};
            if (pick < 15)
            begin
                // Just below, at or just above a power of ten.
                power = 1;
                repeat ($urandom_range(1, 19)) power = power * DECIMAL_BASE;
                word = power + $urandom_range(0, 2) - 1;
            end
            else if (pick >= 25)
            begin
                // Random length so that every digit count shows up.
                nbits = $urandom_range(1, VALUE_PORT_W);
                word  = word >> (VALUE_PORT_W - nbits);
            end
            offer_word(word, "");
        end

        @(negedge clk);
        src_valid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        error_count += pending_digits.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/b2da_pkg.sv
hdl/binary_to_decimal_ascii.sv
hdl/b2da_checker.sv
sim/binary_to_decimal_ascii_tb.sv
